[hw/rtl/ebml_pkg.sv]
// Shared codes, container ID table and small decode helpers for the EBML parser.
// Used by ebml_element_stream_parser and ebml_checker. No dependencies.
`timescale 1ns / 1ps

package ebml_pkg;

    typedef logic [2:0] t_role;
    typedef logic [1:0] t_phase;

    localparam t_role ROLE_HDR_PEND = 3'd0;
    localparam t_role ROLE_HDR_DONE = 3'd1;
    localparam t_role ROLE_LEAF     = 3'd2;
    localparam t_role ROLE_SKIP     = 3'd3;
    localparam t_role ROLE_IGNORE   = 3'd4;

    localparam t_phase PH_IDLE = 2'd0;
    localparam t_phase PH_ID   = 2'd1;
    localparam t_phase PH_SIZE = 2'd2;
    localparam t_phase PH_LEAF = 2'd3;

    localparam int NUM_CONT = 23;
    localparam logic [31:0] CONT_IDS [NUM_CONT] = '{
        32'h1A45DFA3, 32'h18538067, 32'h114D9B74, 32'h00004DBB, 32'h1549A966,
        32'h1654AE6B, 32'h000000AE, 32'h000000E0, 32'h000000E1, 32'h00007670,
        32'h1254C367, 32'h00007373, 32'h000063C0, 32'h000067C8, 32'h1941A469,
        32'h000061A7, 32'h1F43B675, 32'h1C53BB6B, 32'h1043A770, 32'h00006D80,
        32'h00006240, 32'h00005034, 32'h00005035
    };

    function automatic logic is_container_id(input logic [31:0] id);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_CONT; i++) begin
            if (CONT_IDS[i] == id) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Length of a vint from the position of its leading one; 0 when no marker.
    function automatic logic [3:0] marker_len(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 8; k >= 1; k--) begin
            if (b[8-k]) begin
                n = 4'(k);
            end
        end
        return n;
    endfunction

    // All-ones value of a size field of the given length (reserved "unknown").
    function automatic logic [55:0] unknown_size(input logic [3:0] len);
        logic [55:0] v;
        case (len)
            4'd1:    v = 56'h7F;
            4'd2:    v = 56'h3FFF;
            4'd3:    v = 56'h1FFFFF;
            4'd4:    v = 56'hFFFFFFF;
            4'd5:    v = 56'h7FFFFFFFF;
            4'd6:    v = 56'h3FFFFFFFFFF;
            4'd7:    v = 56'h1FFFFFFFFFFFF;
            4'd8:    v = 56'hFFFFFFFFFFFFFF;
            default: v = 56'h0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/ebml_element_stream_parser.sv]
// EBML element stream parser: byte-wise ID/size decode with a nesting stack.
// Depends on ebml_pkg (role and phase codes, container table, vint helpers).
//
// One byte is taken per clock and every byte gives exactly one result, in the
// next cycle, from the output register. The complete decode of a byte (vint
// marker, ID/size accumulation, level-end compares against the stack and the
// stack update) sits in one combinational stage ahead of that register, so a
// new byte is accepted in every cycle in which the output register is empty or
// its result is taken; o_stall rises only when the output register is full and
// the consumer stalls. Assert i_start_req with the first byte of a payload; the
// stream_length register is sampled on that byte. Nesting is tracked down to
// MAX_DEPTH levels; deeper containers are reported as flagged leaves.
`timescale 1ns / 1ps

module ebml_element_stream_parser #(
    parameter int MAX_DEPTH = 8,
    localparam int LVL_W = $clog2(MAX_DEPTH + 1),
    localparam int CLS_W = $clog2(MAX_DEPTH + 2)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [31:0]          i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_start_req,
    output logic                 o_valid,
    input  logic                 i_stall,
    output ebml_pkg::t_role      o_role,
    output logic [31:0]          o_element_id,
    output logic [31:0]          o_element_size,
    output logic [LVL_W-1:0]     o_depth,
    output logic                 o_is_container,
    output logic                 o_depth_overflow,
    output logic [CLS_W-1:0]     o_levels_closed,
    output logic                 o_stream_done
);
    import ebml_pkg::*;

    // parse state
    logic [31:0]        r_stream_length;
    logic [31:0]        r_level_end [0:MAX_DEPTH];
    logic [MAX_DEPTH:0] r_level_broken;
    logic [LVL_W-1:0]   r_open_levels;
    logic [31:0]        r_byte_offset;
    t_phase             r_phase;
    logic [3:0]         r_hdr_left;
    logic [31:0]        r_id;
    logic [55:0]        r_size;
    logic [3:0]         r_size_len;
    logic [31:0]        r_leaf_left;

    logic [MAX_DEPTH:0] n_level_broken;
    logic [LVL_W-1:0]   n_open_levels;
    logic [31:0]        n_byte_offset;
    t_phase             n_phase;
    logic [3:0]         n_hdr_left;
    logic [31:0]        n_id;
    logic [55:0]        n_size;
    logic [3:0]         n_size_len;
    logic [31:0]        n_leaf_left;
    logic [31:0]        n_end0;

    // output register
    logic               r_out_valid;
    t_role              r_role;
    logic [31:0]        r_out_id;
    logic [31:0]        r_out_size;
    logic [LVL_W-1:0]   r_depth;
    logic               r_cont;
    logic               r_ovf;
    logic [CLS_W-1:0]   r_closed;
    logic               r_done;

    t_role              n_role;
    logic [31:0]        n_out_id;
    logic [31:0]        n_out_size;
    logic [LVL_W-1:0]   n_depth;
    logic               n_cont;
    logic               n_ovf;
    logic [CLS_W-1:0]   n_closed;
    logic               n_done;

    logic               accept;
    logic [LVL_W-1:0]   lvl;
    logic [LVL_W-1:0]   lvl_p1;
    logic [31:0]        cur_offset;
    logic [31:0]        cur_end0;
    t_phase             cur_phase;
    logic [MAX_DEPTH:0] cur_broken;
    logic [31:0]        end_lvl;
    logic [31:0]        rem;
    logic [31:0]        off_new;
    logic               active;
    logic               brk;
    logic               open_new;
    logic               wr_end;
    logic [31:0]        wr_end_val;
    logic [3:0]         mlen;
    logic [3:0]         hdr_dec;
    logic [55:0]        acc_new;
    logic [3:0]         hdr_new;
    logic               cont_id;
    logic [MAX_DEPTH:1] close_vec;
    logic [CLS_W-1:0]   ncl;
    logic [LVL_W-1:0]   open_mid;

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_out_valid && i_stall;

    // a start request clears the parse before the byte is handled
    assign cur_offset = i_start_req ? 32'd0 : r_byte_offset;
    assign cur_end0   = i_start_req ? r_stream_length : r_level_end[0];
    assign cur_phase  = i_start_req ? PH_IDLE : r_phase;
    assign cur_broken = i_start_req ? '0 : r_level_broken;
    assign lvl        = i_start_req ? '0 : r_open_levels;
    assign lvl_p1     = lvl + LVL_W'(1);
    assign end_lvl    = (lvl == '0) ? cur_end0 : r_level_end[lvl];
    assign rem        = end_lvl - cur_offset;
    assign off_new    = cur_offset + 32'd1;
    assign active     = cur_offset < cur_end0;
    assign mlen       = marker_len(i_data_byte);
    assign hdr_dec    = (r_hdr_left != 4'd0) ? (r_hdr_left - 4'd1) : 4'd0;
    assign cont_id    = is_container_id(r_id);

    always_comb begin
        n_level_broken = cur_broken;
        n_open_levels  = lvl;
        n_byte_offset  = cur_offset;
        n_phase        = cur_phase;
        n_hdr_left     = r_hdr_left;
        n_id           = r_id;
        n_size         = r_size;
        n_size_len     = r_size_len;
        n_leaf_left    = r_leaf_left;
        n_end0         = cur_end0;

        n_role     = ROLE_IGNORE;
        n_out_id   = 32'd0;
        n_out_size = 32'd0;
        n_depth    = '0;
        n_cont     = 1'b0;
        n_ovf      = 1'b0;
        n_closed   = '0;
        n_done     = 1'b0;

        brk        = 1'b0;
        open_new   = 1'b0;
        wr_end     = 1'b0;
        wr_end_val = off_new + r_size[31:0];
        acc_new    = r_size;
        hdr_new    = hdr_dec;
        close_vec  = '0;
        ncl        = '0;
        open_mid   = lvl;

        if (active) begin
            n_depth = lvl;
            n_role  = ROLE_SKIP;
            if (!cur_broken[lvl]) begin
                case (cur_phase)
                    PH_IDLE: begin
                        if (rem < 32'd2 || mlen == 4'd0 || {28'd0, mlen} >= rem) begin
                            brk = 1'b1;
                        end else begin
                            n_id       = {24'd0, i_data_byte};
                            n_size     = 56'd0;
                            n_size_len = 4'd0;
                            n_hdr_left = mlen - 4'd1;
                            n_phase    = (mlen == 4'd1) ? PH_SIZE : PH_ID;
                            n_role     = ROLE_HDR_PEND;
                            n_out_id   = {24'd0, i_data_byte};
                        end
                    end
                    PH_ID: begin
                        n_id       = {r_id[23:0], i_data_byte};
                        n_hdr_left = hdr_dec;
                        if (hdr_dec == 4'd0) begin
                            n_phase = PH_SIZE;
                        end
                        n_role   = ROLE_HDR_PEND;
                        n_out_id = {r_id[23:0], i_data_byte};
                    end
                    PH_SIZE: begin
                        if (r_size_len == 4'd0) begin
                            acc_new = {48'd0, i_data_byte & (8'hFF >> mlen)};
                            hdr_new = mlen - 4'd1;
                            if (mlen == 4'd0 || {28'd0, mlen} > rem) begin
                                brk = 1'b1;
                            end else begin
                                n_size_len = mlen;
                            end
                        end else begin
                            acc_new = {r_size[47:0], i_data_byte};
                            hdr_new = hdr_dec;
                        end
                        if (!brk) begin
                            n_size     = acc_new;
                            n_hdr_left = hdr_new;
                            n_out_id   = r_id;
                            n_out_size = acc_new[31:0];
                            wr_end_val = off_new + acc_new[31:0];
                            if (hdr_new != 4'd0) begin
                                n_role = ROLE_HDR_PEND;
                            end else if (acc_new == unknown_size(n_size_len) ||
                                         acc_new >= {24'd0, rem}) begin
                                // unknown size, or element would run past its level
                                brk = 1'b1;
                            end else begin
                                n_role = ROLE_HDR_DONE;
                                n_cont = cont_id;
                                if (cont_id && lvl < LVL_W'(MAX_DEPTH)) begin
                                    open_new                = 1'b1;
                                    wr_end                  = 1'b1;
                                    open_mid                = lvl_p1;
                                    n_level_broken[lvl_p1]  = 1'b0;
                                    n_phase                 = PH_IDLE;
                                end else begin
                                    n_ovf       = cont_id;
                                    n_leaf_left = acc_new[31:0];
                                    n_phase     = (acc_new[31:0] != 32'd0) ? PH_LEAF : PH_IDLE;
                                end
                            end
                        end
                    end
                    default: begin
                        n_role      = ROLE_LEAF;
                        n_out_id    = r_id;
                        n_out_size  = r_size[31:0];
                        n_cont      = cont_id;
                        n_ovf       = cont_id;
                        n_leaf_left = (r_leaf_left != 32'd0) ? (r_leaf_left - 32'd1) : 32'd0;
                        if (r_leaf_left <= 32'd1) begin
                            n_phase = PH_IDLE;
                        end
                    end
                endcase
            end

            if (brk) begin
                n_level_broken[lvl] = 1'b1;
                n_phase             = PH_IDLE;
                n_role              = ROLE_SKIP;
                n_out_id            = 32'd0;
                n_out_size          = 32'd0;
            end

            n_byte_offset = off_new;

            // open levels end in a contiguous run from the innermost one
            for (int k = 1; k <= MAX_DEPTH; k++) begin
                close_vec[k] = (LVL_W'(k) <= lvl && r_level_end[k] == off_new) ||
                               (open_new && LVL_W'(k) == lvl_p1 && acc_new == 56'd0);
            end
            for (int k = 1; k <= MAX_DEPTH; k++) begin
                ncl = ncl + CLS_W'(close_vec[k]);
                if (close_vec[k]) begin
                    n_level_broken[k] = 1'b0;
                end
            end
            n_open_levels = open_mid - LVL_W'(ncl);
            n_done        = (off_new == cur_end0);
            if (n_done) begin
                n_level_broken[0] = 1'b0;
            end
            n_closed = ncl + CLS_W'(n_done);
            if (n_closed != '0) begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= 32'd0;
            for (int k = 0; k <= MAX_DEPTH; k++) begin
                r_level_end[k] <= 32'd0;
            end
            r_level_broken <= '0;
            r_open_levels  <= '0;
            r_byte_offset  <= 32'd0;
            r_phase        <= PH_IDLE;
            r_hdr_left     <= 4'd0;
            r_id           <= 32'd0;
            r_size         <= 56'd0;
            r_size_len     <= 4'd0;
            r_leaf_left    <= 32'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_stream_length <= i_cfg_wr_data;
            end
            if (accept) begin
                r_level_end[0] <= n_end0;
                if (wr_end) begin
                    r_level_end[lvl_p1] <= wr_end_val;
                end
                r_level_broken <= n_level_broken;
                r_open_levels  <= n_open_levels;
                r_byte_offset  <= n_byte_offset;
                r_phase        <= n_phase;
                r_hdr_left     <= n_hdr_left;
                r_id           <= n_id;
                r_size         <= n_size;
                r_size_len     <= n_size_len;
                r_leaf_left    <= n_leaf_left;
                r_out_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_role     <= n_role;
            r_out_id   <= n_out_id;
            r_out_size <= n_out_size;
            r_depth    <= n_depth;
            r_cont     <= n_cont;
            r_ovf      <= n_ovf;
            r_closed   <= n_closed;
            r_done     <= n_done;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_role           = r_role;
    assign o_element_id     = r_out_id;
    assign o_element_size   = r_out_size;
    assign o_depth          = r_depth;
    assign o_is_container   = r_cont;
    assign o_depth_overflow = r_ovf;
    assign o_levels_closed  = r_closed;
    assign o_stream_done    = r_done;

endmodule

[hw/rtl/ebml_checker.sv]
// Port-level assertions for ebml_element_stream_parser, bound into every instance of it.
// Depends on ebml_pkg (role codes).
`timescale 1ns / 1ps

module ebml_checker #(
    parameter int MAX_DEPTH = 8,
    localparam int LVL_W = $clog2(MAX_DEPTH + 1),
    localparam int CLS_W = $clog2(MAX_DEPTH + 2)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input ebml_pkg::t_role      o_role,
    input logic [31:0]          o_element_id,
    input logic [31:0]          o_element_size,
    input logic [LVL_W-1:0]     o_depth,
    input logic                 o_is_container,
    input logic                 o_depth_overflow,
    input logic [CLS_W-1:0]     o_levels_closed,
    input logic                 o_stream_done
);
    import ebml_pkg::*;

    // a stalled result keeps its role, ID, size, closed count and done flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_role) && $stable(o_element_id) &&
        $stable(o_element_size) && $stable(o_levels_closed) && $stable(o_stream_done))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a byte outside a payload carries no ID, size, depth, closed levels or done flag
    a_ignore_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_role == ROLE_IGNORE |-> o_element_id == 32'd0 &&
        o_element_size == 32'd0 && o_depth == '0 && o_levels_closed == '0 && !o_stream_done)
        else $error("ignored byte with nonzero fields");

    // the last payload byte always closes the top level
    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stream_done |-> o_levels_closed != '0)
        else $error("stream end without closed level");

    a_ovf_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_depth_overflow |-> o_is_container &&
        (o_role == ROLE_HDR_DONE || o_role == ROLE_LEAF))
        else $error("depth overflow on a non-container result");

endmodule

bind ebml_element_stream_parser ebml_checker #(.MAX_DEPTH(MAX_DEPTH)) u_ebml_checker (.*);
